### rtl/core/twist_lateral_accel_limiter_macros.svh
// assertion macros for the lateral accel limiter checker
`ifndef TWIST_LATERAL_ACCEL_LIMITER_MACROS_SVH
`define TWIST_LATERAL_ACCEL_LIMITER_MACROS_SVH

// same-cycle implication
`define TALA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tala check failed");

// next-cycle implication
`define TALA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tala check failed");

`endif

### rtl/core/tala_pkg.sv
// shared constants for the lateral accel limiter
`default_nettype none

package tala_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned LIMIT_W = 31;
   localparam int unsigned GAIN_W  = 16;
   localparam int unsigned FRAC_W  = 16;
   localparam int unsigned ADDR_W  = 4;
   localparam int unsigned QUO_W   = LIMIT_W + FRAC_W;

   localparam logic [1:0] REG_ACCEL_LIMIT  = 2'd0;
   localparam logic [1:0] REG_SPEED_GAIN   = 2'd1;
   localparam logic [1:0] REG_TURN_GAIN    = 2'd2;
   localparam logic [1:0] REG_TURN_EPSILON = 2'd3;

   localparam logic [LIMIT_W-1:0] ACCEL_LIMIT_RESET  = 31'd655360;
   localparam logic [GAIN_W-1:0]  SPEED_GAIN_RESET   = 16'd0;
   localparam logic [GAIN_W-1:0]  TURN_GAIN_RESET    = 16'd0;
   localparam logic [GAIN_W-1:0]  TURN_EPSILON_RESET = 16'd1;

endpackage

`default_nettype wire

### rtl/core/twist_lateral_accel_limiter.sv
// lateral accel limiter top level: stop latch, speed limit divider, lowpass filters
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_ready  | kind, linear_speed, turn_rate, cleared_flag
//   rsp     | out       | rsp_valid/rsp_ready  | out_speed, out_turn
//   csr     | in/out    | psel/penable/pready  | apb register write and read
//
// an event word is taken while idle and gives no result
// a small-turn command goes from decide straight to done; any other command passes
// compare and filter steps; a limited one also the one-bit-a-cycle divider (47 steps)
// the shared 33x33 multiplier forms the product and all four filter terms in turn
// reset clears latch, filters, rsp_valid, reloads registers; stalled results hold
`default_nettype none

module twist_lateral_accel_limiter
   import tala_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_kind,
   input  wire logic signed [DATA_W-1:0] req_linear_speed,
   input  wire logic signed [DATA_W-1:0] req_turn_rate,
   input  wire logic                     req_cleared_flag,

   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [DATA_W-1:0]      rsp_out_speed,
   output logic signed [DATA_W-1:0]      rsp_out_turn,

   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [ADDR_W-1:0]        paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_CMP,
      S_DIV,
      S_DIVFIX,
      S_SF1,
      S_SF2,
      S_SF3,
      S_TF2,
      S_TF3,
      S_DONE
   } state_type;

   localparam int unsigned CNT_W = $clog2(QUO_W);
   localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QUO_W - 1);
   localparam logic [GAIN_W:0] ONE_Q16 = (GAIN_W+1)'(1) << FRAC_W;

   state_type state_ff, state_in;

   logic [LIMIT_W-1:0] accel_ff, accel_in;
   logic [GAIN_W-1:0]  sgain_ff, sgain_in;
   logic [GAIN_W-1:0]  tgain_ff, tgain_in;
   logic [GAIN_W-1:0]  eps_ff, eps_in;

   logic                     latch_ff, latch_in;
   logic signed [DATA_W-1:0] sfilt_ff, sfilt_in;
   logic signed [DATA_W-1:0] tfilt_ff, tfilt_in;

   logic signed [DATA_W-1:0] raw_ff, raw_in;
   logic signed [DATA_W-1:0] w_ff, w_in;
   logic signed [DATA_W-1:0] sp_ff, sp_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic signed [63:0]       acc_ff, acc_in;
   logic [QUO_W-1:0]         dq_ff, dq_in;
   logic [DATA_W-1:0]        dr_ff, dr_in;
   logic [DATA_W-1:0]        dd_ff, dd_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [DATA_W-1:0] res_speed_ff, res_speed_in;
   logic signed [DATA_W-1:0] res_turn_ff, res_turn_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_speed_ff, rsp_speed_in;
   logic signed [DATA_W-1:0] rsp_turn_ff, rsp_turn_in;

   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] mul_full;
   logic signed [DATA_W-1:0] v_eff;
   logic [DATA_W-1:0] mag_w;
   logic [63:0]       mag_p;
   logic [63:0]       lim_q32;
   logic signed [63:0] filt_sum;
   logic signed [DATA_W-1:0] filt_new;
   logic [32:0] div_shift;
   logic [33:0] div_diff;
   logic        div_ge;
   logic        cfg_wr;
   logic        req_take;

   assign req_take = req_valid && req_ready;
   assign cfg_wr   = psel && penable && pwrite;
   assign pready   = 1'b1;

   assign v_eff    = latch_ff ? '0 : raw_ff;
   assign mag_w    = w_ff[DATA_W-1] ? DATA_W'(-w_ff) : DATA_W'(w_ff);
   assign mag_p    = prod_ff[63] ? 64'(-prod_ff) : 64'(prod_ff);
   assign lim_q32  = {17'd0, accel_ff, 16'd0};
   assign filt_sum = acc_ff + prod_ff;
   assign filt_new = filt_sum[FRAC_W+DATA_W-1:FRAC_W];

   assign div_shift = {dr_ff, dq_ff[QUO_W-1]};
   assign div_diff  = {1'b0, div_shift} - {2'b00, dd_ff};
   assign div_ge    = !div_diff[33];

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         S_DECIDE: begin
            mul_a = 33'(v_eff);
            mul_b = 33'(w_ff);
         end
         S_SF1: begin
            mul_a = {17'd0, sgain_ff};
            mul_b = 33'(sfilt_ff);
         end
         S_SF2: begin
            mul_a = {16'd0, ONE_Q16 - {1'b0, sgain_ff}};
            mul_b = 33'(sp_ff);
         end
         S_SF3: begin
            mul_a = {17'd0, tgain_ff};
            mul_b = 33'(tfilt_ff);
         end
         S_TF2: begin
            mul_a = {16'd0, ONE_Q16 - {1'b0, tgain_ff}};
            mul_b = 33'(w_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   always_comb begin
      prdata = '0;
      unique case (paddr[3:2])
         REG_ACCEL_LIMIT:  prdata = {1'b0, accel_ff};
         REG_SPEED_GAIN:   prdata = {16'd0, sgain_ff};
         REG_TURN_GAIN:    prdata = {16'd0, tgain_ff};
         REG_TURN_EPSILON: prdata = {16'd0, eps_ff};
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      accel_in     = accel_ff;
      sgain_in     = sgain_ff;
      tgain_in     = tgain_ff;
      eps_in       = eps_ff;
      latch_in     = latch_ff;
      sfilt_in     = sfilt_ff;
      tfilt_in     = tfilt_ff;
      raw_in       = raw_ff;
      w_in         = w_ff;
      sp_in        = sp_ff;
      prod_in      = mul_full[63:0];
      acc_in       = acc_ff;
      dq_in        = dq_ff;
      dr_in        = dr_ff;
      dd_in        = dd_ff;
      cnt_in       = cnt_ff;
      res_speed_in = res_speed_ff;
      res_turn_in  = res_turn_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_speed_in = rsp_speed_ff;
      rsp_turn_in  = rsp_turn_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cfg_wr) begin
         unique case (paddr[3:2])
            REG_ACCEL_LIMIT:  accel_in = pwdata[LIMIT_W-1:0];
            REG_SPEED_GAIN:   sgain_in = pwdata[GAIN_W-1:0];
            REG_TURN_GAIN:    tgain_in = pwdata[GAIN_W-1:0];
            REG_TURN_EPSILON: eps_in   = pwdata[GAIN_W-1:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_kind) begin
                  if (req_cleared_flag) begin
                     latch_in = 1'b0;
                  end
               end else begin
                  latch_in = latch_ff || (req_linear_speed == '0);
                  raw_in   = req_linear_speed;
                  w_in     = req_turn_rate;
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            if (mag_w < {16'd0, eps_ff}) begin
               res_speed_in = raw_ff;
               res_turn_in  = w_ff;
               state_in     = S_DONE;
            end else begin
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            sp_in = v_eff;
            if (mag_p > lim_q32) begin
               dq_in    = {accel_ff, 16'd0};
               dr_in    = '0;
               dd_in    = mag_w;
               cnt_in   = DIV_LAST;
               state_in = S_DIV;
            end else begin
               state_in = S_SF1;
            end
         end
         S_DIV: begin
            dr_in = div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
            dq_in = {dq_ff[QUO_W-2:0], div_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_DIVFIX;
            end
         end
         S_DIVFIX: begin
            if (w_ff[DATA_W-1]) begin
               if ((|dq_ff[QUO_W-1:DATA_W]) || (dq_ff[DATA_W-1] && (|dq_ff[DATA_W-2:0]))) begin
                  sp_in = {1'b1, {(DATA_W-1){1'b0}}};
               end else begin
                  sp_in = -$signed(dq_ff[DATA_W-1:0]);
               end
            end else begin
               if (|dq_ff[QUO_W-1:DATA_W-1]) begin
                  sp_in = {1'b0, {(DATA_W-1){1'b1}}};
               end else begin
                  sp_in = $signed(dq_ff[DATA_W-1:0]);
               end
            end
            state_in = S_SF1;
         end
         S_SF1: begin
            state_in = S_SF2;
         end
         S_SF2: begin
            acc_in   = prod_ff;
            state_in = S_SF3;
         end
         S_SF3: begin
            sfilt_in = filt_new;
            state_in = S_TF2;
         end
         S_TF2: begin
            acc_in   = prod_ff;
            state_in = S_TF3;
         end
         S_TF3: begin
            tfilt_in     = filt_new;
            res_speed_in = latch_ff ? '0 : sfilt_ff;
            res_turn_in  = filt_new;
            state_in     = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = res_speed_ff;
               rsp_turn_in  = res_turn_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         accel_ff     <= ACCEL_LIMIT_RESET;
         sgain_ff     <= SPEED_GAIN_RESET;
         tgain_ff     <= TURN_GAIN_RESET;
         eps_ff       <= TURN_EPSILON_RESET;
         latch_ff     <= 1'b0;
         sfilt_ff     <= '0;
         tfilt_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         accel_ff     <= accel_in;
         sgain_ff     <= sgain_in;
         tgain_ff     <= tgain_in;
         eps_ff       <= eps_in;
         latch_ff     <= latch_in;
         sfilt_ff     <= sfilt_in;
         tfilt_ff     <= tfilt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      raw_ff       <= raw_in;
      w_ff         <= w_in;
      sp_ff        <= sp_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      dq_ff        <= dq_in;
      dr_ff        <= dr_in;
      dd_ff        <= dd_in;
      cnt_ff       <= cnt_in;
      res_speed_ff <= res_speed_in;
      res_turn_ff  <= res_turn_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_turn_ff  <= rsp_turn_in;
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_speed = rsp_speed_ff;
   assign rsp_out_turn  = rsp_turn_ff;

endmodule

`default_nettype wire

### rtl/core/tala_checker.sv
// port-level checks for the lateral accel limiter, bound to the top level
`default_nettype none
`include "twist_lateral_accel_limiter_macros.svh"

module tala_checker
   import tala_pkg::*;
(
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_ready,
   input wire logic                     req_kind,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire logic signed [DATA_W-1:0] rsp_out_speed,
   input wire logic signed [DATA_W-1:0] rsp_out_turn
);

   // result word holds while stalled
   `TALA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `TALA_ASSERT_NXT(a_spd_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_out_speed))
   `TALA_ASSERT_NXT(a_trn_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_out_turn))

   // a command word keeps the block busy for the next cycle
   `TALA_ASSERT_NXT(a_cmd_busy, clock, reset, req_valid && req_ready && !req_kind, !req_ready)

   // reset leaves the block ready with no result pending
   `TALA_ASSERT_NXT(a_reset_idle, clock, 1'b0, reset, req_ready && !rsp_valid)

endmodule

bind twist_lateral_accel_limiter tala_checker u_tala_checker (.*);

`default_nettype wire

### bench/tb_twist_lateral_accel_limiter.sv
// self-checking testbench for the lateral accel limiter with lowpass filters
module tb_twist_lateral_accel_limiter;
   timeunit 1ns;
   timeprecision 1ps;
   import tala_pkg::*;

   localparam logic KIND_COMMAND = 1'b0;
   localparam logic KIND_EVENT   = 1'b1;
   localparam int   Q_ONE        = 65536;
   localparam int   DRAIN_CYCLES = 80;
   localparam int   REPORT_LIMIT = 10;
   localparam int   PHASE_WORDS  = 250;
   localparam longint SPEED_MAX  = 64'sd2147483647;
   localparam longint SPEED_MIN  = -64'sd2147483648;

   typedef struct packed {
      logic signed [DATA_W-1:0] speed;
      logic signed [DATA_W-1:0] turn;
   } twist_type;

   logic                     clock;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_ready;
   logic                     req_kind         = KIND_COMMAND;
   logic signed [DATA_W-1:0] req_linear_speed = '0;
   logic signed [DATA_W-1:0] req_turn_rate    = '0;
   logic                     req_cleared_flag = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready        = 1'b0;
   logic signed [DATA_W-1:0] rsp_out_speed;
   logic signed [DATA_W-1:0] rsp_out_turn;
   logic                     psel             = 1'b0;
   logic                     penable          = 1'b0;
   logic                     pwrite           = 1'b0;
   logic [ADDR_W-1:0]        paddr            = '0;
   logic [31:0]              pwdata           = '0;
   logic [31:0]              prdata;
   logic                     pready;

   // predictor copy of registers and state
   logic [LIMIT_W-1:0]       limit_cfg      = ACCEL_LIMIT_RESET;
   logic [GAIN_W-1:0]        speed_gain_cfg = SPEED_GAIN_RESET;
   logic [GAIN_W-1:0]        turn_gain_cfg  = TURN_GAIN_RESET;
   logic [GAIN_W-1:0]        turn_eps_cfg   = TURN_EPSILON_RESET;
   logic                     stop_latched   = 1'b0;
   logic signed [DATA_W-1:0] speed_state    = '0;
   logic signed [DATA_W-1:0] turn_state     = '0;

   twist_type expected_twist[$];
   twist_type oldest_twist;
   int     mismatch_count = 0;
   int     stall_pct      = 0;
   int     stall_left     = 0;
   int     hold_req       = 0;
   int     hold_left      = 0;
   bit     gaps_on        = 1'b0;

   twist_lateral_accel_limiter u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_linear_speed (req_linear_speed),
      .req_turn_rate    (req_turn_rate),
      .req_cleared_flag (req_cleared_flag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_speed    (rsp_out_speed),
      .rsp_out_turn     (rsp_out_turn),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("twist_lateral_accel_limiter: mismatch");
      $finish;
   end

   function automatic logic signed [DATA_W-1:0] lowpass_q16(
      input logic signed [DATA_W-1:0] prev,
      input longint                   x,
      input logic [GAIN_W-1:0]        g
   );
      longint gl;
      longint acc;
      gl  = g;
      acc = gl * prev + (longint'(Q_ONE) - gl) * x;
      acc = acc >>> FRAC_W;
      return acc[DATA_W-1:0];
   endfunction

   function automatic void predict_twist(
      input logic                     kind,
      input logic signed [DATA_W-1:0] lin,
      input logic signed [DATA_W-1:0] turn,
      input logic                     flag
   );
      longint      raw_v;
      longint      v;
      longint      w;
      longint      mag_w;
      longint      eps_l;
      longint      prod;
      longint      lim;
      longint      sp;
      logic [63:0] mag_p;
      twist_type   word;
      if (kind == KIND_EVENT) begin
         if (flag) stop_latched = 1'b0;
      end else begin
         raw_v = lin;
         w     = turn;
         eps_l = turn_eps_cfg;
         if (raw_v == 0) stop_latched = 1'b1;
         if (stop_latched) v = 0;
         else v = raw_v;
         mag_w = (w < 0) ? -w : w;
         if (mag_w < eps_l) begin
            // small turn bypasses limiting and filtering
            word.speed = lin;
            word.turn  = turn;
         end else begin
            prod  = v * w;
            mag_p = (prod < 0) ? -prod : prod;
            lim   = limit_cfg;
            lim   = lim * Q_ONE;
            sp    = v;
            if (mag_p > lim && w != 0) begin
               sp = lim / w;
               if (sp > SPEED_MAX) sp = SPEED_MAX;
               if (sp < SPEED_MIN) sp = SPEED_MIN;
            end
            speed_state = lowpass_q16(speed_state, sp, speed_gain_cfg);
            turn_state  = lowpass_q16(turn_state, w, turn_gain_cfg);
            word.speed  = stop_latched ? '0 : speed_state;
            word.turn   = turn_state;
         end
         expected_twist.push_back(word);
      end
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t %s: expected %h, got %h", $time, field, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_twist.size() == 0) begin
            report_mismatch("unexpected word speed", '0, rsp_out_speed);
         end else begin
            oldest_twist = expected_twist.pop_front();
            if (rsp_out_speed !== oldest_twist.speed)
               report_mismatch("out_speed", oldest_twist.speed, rsp_out_speed);
            if (rsp_out_turn !== oldest_twist.turn)
               report_mismatch("out_turn", oldest_twist.turn, rsp_out_turn);
         end
      end
   end

   // receiver: random stalls plus a counted long hold-off on request
   always @(posedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left = $urandom_range(0, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_word(input logic kind, input logic signed [DATA_W-1:0] lin,
                            input logic signed [DATA_W-1:0] turn, input logic flag);
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_linear_speed <= lin;
      req_turn_rate    <= turn;
      req_cleared_flag <= flag;
      do @(posedge clock); while (!req_ready);
      predict_twist(kind, lin, turn, flag);
   endtask

   task automatic send_command(input logic signed [DATA_W-1:0] lin,
                               input logic signed [DATA_W-1:0] turn);
      send_word(KIND_COMMAND, lin, turn, 1'($urandom_range(0, 1)));
   endtask

   task automatic send_event(input logic flag);
      send_word(KIND_EVENT, $urandom, $urandom, flag);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_twist.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_ACCEL_LIMIT:  limit_cfg      = data[LIMIT_W-1:0];
         REG_SPEED_GAIN:   speed_gain_cfg = data[GAIN_W-1:0];
         REG_TURN_GAIN:    turn_gain_cfg  = data[GAIN_W-1:0];
         REG_TURN_EPSILON: turn_eps_cfg   = data[GAIN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [1:0] idx);
      logic [31:0] want;
      case (idx)
         REG_ACCEL_LIMIT:  want = {1'b0, limit_cfg};
         REG_SPEED_GAIN:   want = {16'd0, speed_gain_cfg};
         REG_TURN_GAIN:    want = {16'd0, turn_gain_cfg};
         default:          want = {16'd0, turn_eps_cfg};
      endcase
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== want) report_mismatch("register read", want, prdata);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_all_registers();
      csr_read_check(REG_ACCEL_LIMIT);
      csr_read_check(REG_SPEED_GAIN);
      csr_read_check(REG_TURN_GAIN);
      csr_read_check(REG_TURN_EPSILON);
   endtask

   task automatic test_register_access();
      read_all_registers();
      csr_write(REG_ACCEL_LIMIT, 32'hFFFF_FFFF);
      csr_write(REG_SPEED_GAIN, 32'hFFFF_0000);
      csr_write(REG_TURN_GAIN, 32'h0001_FFFF);
      csr_write(REG_TURN_EPSILON, 32'h5A5A_8001);
      read_all_registers();
      csr_write(REG_ACCEL_LIMIT, {1'b1, ACCEL_LIMIT_RESET});
      csr_write(REG_SPEED_GAIN, {16'hA5A5, SPEED_GAIN_RESET});
      csr_write(REG_TURN_GAIN, {16'h5A5A, TURN_GAIN_RESET});
      csr_write(REG_TURN_EPSILON, {16'hFFFF, TURN_EPSILON_RESET});
      read_all_registers();
   endtask

   task automatic test_pass_and_limit();
      send_command(2 * Q_ONE, Q_ONE);
      send_command(20 * Q_ONE, Q_ONE);
      send_command(20 * Q_ONE, -2 * Q_ONE);
      send_command(-20 * Q_ONE, 2 * Q_ONE);
      send_command(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_command(32'sh8000_0000, 32'sh8000_0000);
      send_command(Q_ONE, 32'sh8000_0000);
      send_command(3 * Q_ONE, 7);
      wait_drained();
   endtask

   task automatic test_stop_latch();
      send_command(0, Q_ONE);
      send_command(5 * Q_ONE, Q_ONE);
      send_event(1'b0);
      send_command(5 * Q_ONE, Q_ONE);
      send_event(1'b1);
      send_command(5 * Q_ONE, Q_ONE);
      wait_drained();
   endtask

   task automatic test_small_turn();
      csr_write(REG_TURN_EPSILON, 32'h0000_FFFF);
      send_command(7 * Q_ONE, Q_ONE / 2);
      send_command(7 * Q_ONE, -65534);
      send_command(0, 100);
      send_command(3 * Q_ONE, 200);
      send_command(3 * Q_ONE, 2 * Q_ONE);
      send_event(1'b1);
      wait_drained();
      // zero epsilon: a zero turn goes through the filters
      csr_write(REG_TURN_EPSILON, 32'h0000_0000);
      send_command(4 * Q_ONE, 0);
      wait_drained();
   endtask

   task automatic test_filter_gains();
      csr_write(REG_SPEED_GAIN, 32'h0000_FFFF);
      csr_write(REG_TURN_GAIN, 32'h0000_FFFF);
      csr_write(REG_ACCEL_LIMIT, 32'h0000_0000);
      send_command(4 * Q_ONE, Q_ONE);
      wait_drained();
      csr_write(REG_SPEED_GAIN, 32'h0000_8000);
      csr_write(REG_TURN_GAIN, 32'h0000_8000);
      csr_write(REG_ACCEL_LIMIT, 32'h7FFF_FFFF);
      send_command(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_command(32'sh8000_0000, 32'sh8000_0000);
      send_command(32'sh8000_0000, 32'sh7FFF_FFFF);
      wait_drained();
   endtask

   function automatic logic signed [DATA_W-1:0] rand_speed();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return 32'sh7FFF_FFFF;
         2:       return 32'sh8000_0000;
         3, 4:    return $urandom;
         default: return $urandom_range(0, 32'h003F_FFFF) - 32'h0020_0000;
      endcase
   endfunction

   function automatic logic signed [DATA_W-1:0] rand_turn();
      logic signed [DATA_W-1:0] mag;
      case ($urandom_range(0, 11))
         0:       return '0;
         1:       return 32'sh7FFF_FFFF;
         2:       return 32'sh8000_0000;
         3:       return $urandom;
         4, 5: begin
            // around the bypass threshold
            mag = $urandom_range(0, 2 * turn_eps_cfg + 1);
            return $urandom_range(0, 1) ? -mag : mag;
         end
         default: return $urandom_range(0, 32'h0007_FFFF) - 32'h0004_0000;
      endcase
   endfunction

   function automatic logic [31:0] rand_limit_data();
      logic [LIMIT_W-1:0] lim;
      case ($urandom_range(0, 4))
         0:       lim = '0;
         1:       lim = '1;
         2:       lim = ACCEL_LIMIT_RESET;
         3:       lim = LIMIT_W'($urandom_range(0, 32'h00FF_FFFF));
         default: lim = LIMIT_W'($urandom);
      endcase
      return {1'($urandom_range(0, 1)), lim};
   endfunction

   function automatic logic [31:0] rand_gain_data();
      logic [GAIN_W-1:0] g;
      case ($urandom_range(0, 3))
         0:       g = '0;
         1:       g = '1;
         2:       g = 16'h8000;
         default: g = GAIN_W'($urandom);
      endcase
      return {16'($urandom), g};
   endfunction

   function automatic logic [31:0] rand_eps_data();
      logic [GAIN_W-1:0] e;
      case ($urandom_range(0, 4))
         0:       e = '0;
         1:       e = 16'd1;
         2:       e = '1;
         3:       e = GAIN_W'($urandom_range(0, 16'h2000));
         default: e = GAIN_W'($urandom);
      endcase
      return {16'($urandom), e};
   endfunction

   task automatic test_backpressure();
      csr_write(REG_ACCEL_LIMIT, {1'b0, ACCEL_LIMIT_RESET});
      csr_write(REG_TURN_EPSILON, 32'h0000_0001);
      hold_req = 400;
      repeat (24) send_command(rand_speed(), rand_turn());
      wait_drained();
   endtask

   task automatic test_random_traffic();
      int burst_left;
      int gap;
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               csr_write(REG_ACCEL_LIMIT, 32'h0000_0000);
               csr_write(REG_SPEED_GAIN, 32'h0000_0000);
               csr_write(REG_TURN_GAIN, 32'h0000_0000);
               csr_write(REG_TURN_EPSILON, 32'h0000_0000);
               stall_pct = 0;
               gaps_on   = 1'b0;
            end
            1: begin
               csr_write(REG_ACCEL_LIMIT, 32'hFFFF_FFFF);
               csr_write(REG_SPEED_GAIN, 32'hFFFF_FFFF);
               csr_write(REG_TURN_GAIN, 32'hFFFF_FFFF);
               csr_write(REG_TURN_EPSILON, 32'hFFFF_FFFF);
               stall_pct = 40;
               gaps_on   = 1'b1;
            end
            default: begin
               csr_write(REG_ACCEL_LIMIT, rand_limit_data());
               csr_write(REG_SPEED_GAIN, rand_gain_data());
               csr_write(REG_TURN_GAIN, rand_gain_data());
               csr_write(REG_TURN_EPSILON, rand_eps_data());
               stall_pct = (phase == 3) ? 70 : 15;
               gaps_on   = 1'b1;
            end
         endcase
         burst_left = 0;
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
               if (gaps_on && gap > 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            burst_left--;
            if ($urandom_range(0, 7) == 0) send_event(1'($urandom_range(0, 1)));
            else send_command(rand_speed(), rand_turn());
         end
         wait_drained();
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_access();
      test_pass_and_limit();
      test_stop_latch();
      test_small_turn();
      test_filter_gains();
      test_backpressure();
      test_random_traffic();
      req_valid <= 1'b0;
      while (expected_twist.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_twist.size() == 0)
         $display("twist_lateral_accel_limiter: match");
      else
         $display("twist_lateral_accel_limiter: mismatch");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/tala_pkg.sv
rtl/core/twist_lateral_accel_limiter.sv
rtl/core/tala_checker.sv
bench/tb_twist_lateral_accel_limiter.sv
